/* rtl/u2a_pkg.sv */
package u2a_pkg;

  // number of decimal digit cells; 32 bits never need more than ten
  localparam int unsigned NumCells  = 10;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned ValueW    = 32;
  // binary bits fed into the cell row per conversion cycle
  localparam int unsigned StepBits  = 4;
  localparam int unsigned ConvSteps = ValueW / StepBits;
  localparam int unsigned HexDigits = ValueW / DigitW;
  localparam int unsigned CharW     = 7;
  localparam int unsigned CntW      = $clog2(ConvSteps);
  localparam int unsigned RemW      = $clog2(NumCells + 1);

  // ascii base codes
  localparam logic [CharW-1:0] CharZero  = 7'd48;
  localparam logic [CharW-1:0] CharAlpha = 7'd55;  // 'A' minus ten

  // per-cycle command to every cell of the row
  typedef struct packed {
    logic load;   // take load digit
    logic conv;   // StepBits shift-add-3 steps, one bit each
    logic shift;  // take the lower neighbor's digit
  } cell_ctrl_t;

  // ascii code of one digit, upper case for hex
  function automatic logic [CharW-1:0] digit_code(input logic [DigitW-1:0] d);
    logic [CharW-1:0] ext;
    ext = {{(CharW-DigitW){1'b0}}, d};
    if (d < DigitW'(10)) begin
      digit_code = CharZero + ext;
    end else begin
      digit_code = CharAlpha + ext;
    end
  endfunction

endpackage

/* rtl/unsigned_to_ascii_digits_core.sv */
// channel  | dir | tdata                  | tuser       | tlast
// s_axis   | in  | [31:0] value           | [0] use_hex | -
// m_axis   | out | [6:0] digit_char, [7]0 | -           | last_digit
//
// decimal: after the accept, the cell row converts 4 bits per cycle in StConv, then
// StEmit scans the digit cells, most significant first, one cell per step.
// hex: nibbles load straight into the cells and StConv is skipped.
// the output register holds a digit while m_axis stalls; the scan waits.
// reset clears the control state only; the cells need no reset.
module unsigned_to_ascii_digits_core
  import u2a_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [0:0]  s_axis_tuser_i,   // [0] use_hex
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [6:0] digit_char, [7] zero
  output logic        m_axis_tlast_o
);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } state_e;

  state_e           state_q;
  logic [ValueW-1:0] val_q;
  logic [CntW-1:0]  cnt_q;
  logic [RemW-1:0]  rem_q;
  logic             seen_q;
  logic             out_valid_q;
  logic [CharW-1:0] out_char_q;
  logic             out_last_q;

  cell_ctrl_t        cell_ctrl;
  logic [DigitW-1:0]   cell_digit [NumCells];
  logic [StepBits-1:0] cell_bits  [NumCells];
  logic [StepBits-1:0] feed_bits;

  logic accept, out_free, top_zero, skip, step, emit;

  assign accept   = s_axis_tvalid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign top_zero = (cell_digit[NumCells-1] == '0);
  assign skip     = !seen_q && top_zero && (rem_q != RemW'(1));
  assign step     = (state_q == StEmit) && (skip || out_free);
  assign emit     = step && !skip;

  // cell row command
  always_comb begin
    cell_ctrl.load  = accept;
    cell_ctrl.conv  = (state_q == StConv);
    cell_ctrl.shift = step;
  end

  // top bits of the value, most significant first
  always_comb begin
    for (int j = 0; j < StepBits; j++) begin
      feed_bits[j] = val_q[ValueW-1-j];
    end
  end

  // row of digit cells, cell 0 the least significant
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    logic [DigitW-1:0]   load_digit;
    logic [DigitW-1:0]   lower_digit;
    logic [StepBits-1:0] lower_bits;

    if (i < HexDigits) begin : g_hex
      assign load_digit = s_axis_tuser_i[0] ? s_axis_tdata_i[i*DigitW +: DigitW] : '0;
    end else begin : g_pad
      assign load_digit = '0;
    end

    if (i == 0) begin : g_first
      assign lower_digit = '0;
      assign lower_bits  = feed_bits;
    end else begin : g_next
      assign lower_digit = cell_digit[i-1];
      assign lower_bits  = cell_bits[i-1];
    end

    u2a_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .load_digit_i (load_digit),
      .shift_digit_i(lower_digit),
      .bits_i       (lower_bits),
      .digit_o      (cell_digit[i]),
      .bits_o       (cell_bits[i])
    );
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      rem_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            cnt_q  <= '0;
            rem_q  <= RemW'(NumCells);
            seen_q <= 1'b0;
            state_q <= s_axis_tuser_i[0] ? StEmit : StConv;
          end
        end
        StConv: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(ConvSteps - 1)) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (step) begin
            rem_q <= rem_q - RemW'(1);
            if (emit) begin
              seen_q <= 1'b1;
            end
            if (rem_q == RemW'(1)) begin
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // value shifter and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q <= s_axis_tdata_i;
    end else if (state_q == StConv) begin
      val_q <= {val_q[ValueW-StepBits-1:0], {StepBits{1'b0}}};
    end
    if (emit) begin
      out_char_q <= digit_code(cell_digit[NumCells-1]);
      out_last_q <= (rem_q == RemW'(1));
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_char_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

/* rtl/u2a_cell.sv */
module u2a_cell
  import u2a_pkg::*;
(
  input  logic                clk_i,
  input  cell_ctrl_t          ctrl_i,
  input  logic [DigitW-1:0]   load_digit_i,
  input  logic [DigitW-1:0]   shift_digit_i,  // digit of the lower neighbor
  input  logic [StepBits-1:0] bits_i,         // bit j enters at step j
  output logic [DigitW-1:0]   digit_o,
  output logic [StepBits-1:0] bits_o          // carries to the upper neighbor
);

  logic [DigitW-1:0] digit_q, digit_d;
  logic [DigitW-1:0] conv_digit;

  // shift-add-3 steps on this digit
  always_comb begin
    logic [DigitW-1:0] d;
    logic [DigitW-1:0] a;
    d = digit_q;
    for (int j = 0; j < StepBits; j++) begin
      a = (d >= DigitW'(5)) ? d + DigitW'(3) : d;
      bits_o[j] = a[DigitW-1];
      d = {a[DigitW-2:0], bits_i[j]};
    end
    conv_digit = d;
  end

  // digit select
  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.load) begin
      digit_d = load_digit_i;
    end else if (ctrl_i.conv) begin
      digit_d = conv_digit;
    end else if (ctrl_i.shift) begin
      digit_d = shift_digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

/* rtl/u2a_checker.sv */
module u2a_checker
  import u2a_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // a stalled digit stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output dropped while stalled");

  // a stalled digit keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output payload changed while stalled");

  // only digit codes leave the block
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o >= 8'd48 && m_axis_tdata_o <= 8'd57) ||
      (m_axis_tdata_o >= 8'd65 && m_axis_tdata_o <= 8'd70))
    else $error("output is not a digit code");

  // a number in flight blocks new requests
  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("request taken before last digit was queued");

  // a taken request is followed by busy
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready right after a request");

endmodule

bind unsigned_to_ascii_digits_core u2a_checker u_u2a_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);
